>>> rtl/mmp_pkg.sv
// Shared types, codes and modular arithmetic helpers for the modular matrix power unit.
// No dependencies; imported by mmp_mac, modular_matrix_power_unit and tb_top.
package mmp_pkg;

   localparam logic [15:0] MODULUS = 16'd65521;

   // Register index of dim, as decoded from the word address.
   localparam logic REG_DIM = 1'b0;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_RUN   = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_INIT,
      ST_STEP,
      ST_MUL,
      ST_DRAIN,
      ST_COPY,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctl_type;

   // 2^16 = 15 mod 65521: first fold of a 32-bit product.
   function automatic logic [20:0] fold_hi(input logic [31:0] p);
      fold_hi = 21'(p[31:16]) * 21'd15 + 21'(p[15:0]);
   endfunction

   // Second fold leaves a value below twice the modulus; one subtract finishes it.
   function automatic logic [15:0] fold_lo(input logic [20:0] f);
      logic [16:0] s;
      s = 17'(f[20:16]) * 17'd15 + 17'(f[15:0]);
      fold_lo = (s >= 17'(MODULUS)) ? 16'(s - 17'(MODULUS)) : s[15:0];
   endfunction

   function automatic logic [15:0] add_mod(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = 17'(a) + 17'(b);
      add_mod = (s >= 17'(MODULUS)) ? 16'(s - 17'(MODULUS)) : s[15:0];
   endfunction

endpackage

>>> rtl/mmp_mac.sv
// Pipelined modular multiply-accumulate: product, two folds mod 65521, running sum.
// Depends on mmp_pkg. Emits one finished dot product per beat flagged last.
module mmp_mac #(
   parameter int TW = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mmp_pkg::mac_ctl_type in_ctl,
   input  logic [15:0]          in_a,
   input  logic [15:0]          in_b,
   input  logic [TW-1:0]        in_tag,
   output logic                 wr_valid,
   output logic [TW-1:0]        wr_tag,
   output logic [15:0]          wr_data,
   output logic                 busy
);
   import mmp_pkg::*;

   mac_ctl_type   ctl1_ff, ctl2_ff, ctl3_ff;
   logic [TW-1:0] tag1_ff, tag2_ff, tag3_ff;
   logic [31:0]   prod_ff;
   logic [20:0]   fold_ff;
   logic [15:0]   red_ff;
   logic [15:0]   acc_ff;
   logic [15:0]   acc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
      end else begin
         ctl1_ff <= in_ctl;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
      end
   end

   always_ff @(posedge clock) begin
      tag1_ff <= in_tag;
      tag2_ff <= tag1_ff;
      tag3_ff <= tag2_ff;
      prod_ff <= 32'(in_a) * 32'(in_b);
      fold_ff <= fold_hi(prod_ff);
      red_ff  <= fold_lo(fold_ff);
      if (ctl3_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   always_comb begin
      acc_in = add_mod(ctl3_ff.first ? 16'd0 : acc_ff, red_ff);
   end

   assign wr_valid = ctl3_ff.valid && ctl3_ff.last;
   assign wr_tag   = tag3_ff;
   assign wr_data  = acc_in;
   assign busy     = ctl1_ff.valid || ctl2_ff.valid || ctl3_ff.valid;

endmodule

>>> rtl/modular_matrix_power_unit.sv
// Modular matrix power unit: base/square/result/scratch memories, one MAC pipeline.
// Writes go straight to memory; a read passes a memory read, then the response register.
// A run does an init pass over the active n*n square (n is the active dim), then per
// multiply an issue pass, a drain and a copy pass; one multiply per set exponent bit
// plus one squaring per further bit. Reset: synchronous; a clearing pass zeroes every
// base memory word before the first beat is taken; dim resets to 1.
module modular_matrix_power_unit #(
   parameter int MAX_DIM = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [5:0]  req_row,
   input  logic [5:0]  req_col,
   input  logic [15:0] req_value,
   input  logic [62:0] req_exponent,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_entry,
   output logic        rsp_done_res,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import mmp_pkg::*;

   localparam int IW    = $clog2(MAX_DIM);
   localparam int NW    = $clog2(MAX_DIM + 1);
   localparam int AW    = 2 * IW;
   localparam int DEPTH = 1 << AW;

   logic [15:0] base_mem   [DEPTH];
   logic [15:0] square_mem [DEPTH];
   logic [15:0] result_mem [DEPTH];
   logic [15:0] scratch_mem[DEPTH];

   state_type    state_ff, state_in;
   logic [AW-1:0] clr_ff;
   logic [6:0]   dim_ff;
   logic [NW-1:0] n_ff;
   logic [NW-1:0] n_act;
   logic [IW-1:0] nm1;
   logic [62:0]  e_ff;
   logic         ph_ff, mode_res_ff;
   logic [IW-1:0] i_ff, j_ff, t_ff, i_in, j_in, t_in;
   logic         last_i, last_j, last_t;

   logic         req_fire, rsp_free, in_range, in_square;
   logic [AW-1:0] req_addr;
   logic         rd_hit_ff;
   logic [15:0]  wval;

   logic         rsp_valid_ff;
   logic [15:0]  rsp_entry_ff;
   logic         rsp_done_ff;

   mac_ctl_type  iss_ctl_ff;
   logic [AW-1:0] iss_tag_ff;
   logic [15:0]  res_rd_ff, sqa_rd_ff, sqb_rd_ff, base_rd_ff, scr_rd_ff;
   logic [AW-1:0] res_ra, sqa_ra, sqb_ra;

   logic         wb_v_ff, wb_to_res_ff, wb_from_base_ff;
   logic [AW-1:0] wb_addr_ff;
   logic [15:0]  wb_data;

   logic         mac_wr_valid, mac_busy;
   logic [AW-1:0] mac_wr_tag;
   logic [15:0]  mac_wr_data;

   // ---------------- configuration port ----------------
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_DIM) ? {25'd0, dim_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= 7'd1;
      end else if (psel && penable && pwrite && pready && paddr[2] == REG_DIM) begin
         dim_ff <= pwdata[6:0];
      end
   end

   always_comb begin
      if (dim_ff == 7'd0) begin
         n_act = NW'(1);
      end else if (dim_ff > 7'(MAX_DIM)) begin
         n_act = NW'(MAX_DIM);
      end else begin
         n_act = NW'(dim_ff);
      end
   end

   // ---------------- request decode ----------------
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && rsp_free;
   assign req_fire  = req_valid && req_ready;
   assign in_range  = ({1'b0, req_row} < 7'(MAX_DIM)) && ({1'b0, req_col} < 7'(MAX_DIM));
   assign in_square = ({1'b0, req_row} < 7'(n_ff)) && ({1'b0, req_col} < 7'(n_ff));
   assign req_addr  = {req_row[IW-1:0], req_col[IW-1:0]};
   assign wval      = (req_value >= MODULUS) ? 16'(req_value - MODULUS) : req_value;

   // ---------------- sequencer ----------------
   assign nm1    = IW'(n_ff - NW'(1));
   assign last_i = (i_ff == nm1);
   assign last_j = (j_ff == nm1);
   assign last_t = (t_ff == nm1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == '1) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_fire && req_op == OP_RUN) begin
               state_in = ST_INIT;
            end else if (req_fire && req_op == OP_READ) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_IDLE;
         ST_INIT: if (last_i && last_j) state_in = ST_STEP;
         ST_STEP: begin
            if (!ph_ff) begin
               if (e_ff == 63'd0) begin
                  state_in = ST_DONE;
               end else if (e_ff[0]) begin
                  state_in = ST_MUL;
               end
            end else if ((e_ff >> 1) != 63'd0) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:   if (last_i && last_j && last_t) state_in = ST_DRAIN;
         ST_DRAIN: if (!mac_busy && !iss_ctl_ff.valid) state_in = ST_COPY;
         ST_COPY:  if (last_i && last_j) state_in = ST_STEP;
         ST_DONE:  if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      i_in = '0;
      j_in = '0;
      t_in = '0;
      unique case (state_ff)
         ST_MUL: begin
            i_in = i_ff;
            j_in = j_ff;
            t_in = last_t ? '0 : t_ff + IW'(1);
            if (last_t) begin
               j_in = last_j ? '0 : j_ff + IW'(1);
               if (last_j) i_in = last_i ? '0 : i_ff + IW'(1);
            end
         end
         ST_INIT, ST_COPY: begin
            i_in = i_ff;
            j_in = last_j ? '0 : j_ff + IW'(1);
            if (last_j) i_in = last_i ? '0 : i_ff + IW'(1);
         end
         default: begin
            i_in = '0;
            j_in = '0;
            t_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_ff      <= '0;
         i_ff        <= '0;
         j_ff        <= '0;
         t_ff        <= '0;
         ph_ff       <= 1'b0;
         mode_res_ff <= 1'b0;
         n_ff        <= NW'(1);
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         t_ff     <= t_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + AW'(1);
         if (req_fire && req_op == OP_RUN) begin
            n_ff  <= n_act;
            ph_ff <= 1'b0;
         end
         if (state_ff == ST_STEP) begin
            if (!ph_ff) begin
               if (e_ff[0]) mode_res_ff <= 1'b1;
               else         ph_ff <= 1'b1;
            end else begin
               ph_ff       <= 1'b0;
               mode_res_ff <= 1'b0;
            end
         end
         if (state_ff == ST_COPY && last_i && last_j) ph_ff <= mode_res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_op == OP_RUN) begin
         e_ff <= req_exponent;
      end else if (state_ff == ST_STEP && ph_ff) begin
         e_ff <= e_ff >> 1;
      end
      if (req_fire) rd_hit_ff <= in_square;
   end

   // ---------------- memories ----------------
   assign res_ra = (state_ff == ST_IDLE) ? req_addr : {i_ff, t_ff};
   assign sqa_ra = {i_ff, t_ff};
   assign sqb_ra = {t_ff, j_ff};
   assign wb_data = wb_from_base_ff ? base_rd_ff : scr_rd_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         base_mem[clr_ff] <= 16'd0;
      end else if (req_fire && req_op == OP_WRITE && in_range) begin
         base_mem[req_addr] <= wval;
      end
      base_rd_ff <= base_mem[{i_ff, j_ff}];
   end

   always_ff @(posedge clock) begin
      if (wb_v_ff && !wb_to_res_ff) square_mem[wb_addr_ff] <= wb_data;
      sqa_rd_ff <= square_mem[sqa_ra];
      sqb_rd_ff <= square_mem[sqb_ra];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_INIT) begin
         result_mem[{i_ff, j_ff}] <= (i_ff == j_ff) ? 16'd1 : 16'd0;
      end else if (wb_v_ff && wb_to_res_ff) begin
         result_mem[wb_addr_ff] <= wb_data;
      end
      res_rd_ff <= result_mem[res_ra];
   end

   always_ff @(posedge clock) begin
      if (mac_wr_valid) scratch_mem[mac_wr_tag] <= mac_wr_data;
      scr_rd_ff <= scratch_mem[{i_ff, j_ff}];
   end

   // write-back stage: base->square during init, scratch->destination during copy
   always_ff @(posedge clock) begin
      if (reset) begin
         wb_v_ff <= 1'b0;
      end else begin
         wb_v_ff <= (state_ff == ST_INIT) || (state_ff == ST_COPY);
      end
      wb_addr_ff      <= {i_ff, j_ff};
      wb_from_base_ff <= (state_ff == ST_INIT);
      wb_to_res_ff    <= (state_ff == ST_COPY) && mode_res_ff;
   end

   // ---------------- multiply issue ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         iss_ctl_ff <= '0;
      end else begin
         iss_ctl_ff.valid <= (state_ff == ST_MUL);
         iss_ctl_ff.first <= (t_ff == '0);
         iss_ctl_ff.last  <= last_t;
      end
      iss_tag_ff <= {i_ff, j_ff};
   end

   mmp_mac #(
      .TW(AW)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (iss_ctl_ff),
      .in_a     (mode_res_ff ? res_rd_ff : sqa_rd_ff),
      .in_b     (sqb_rd_ff),
      .in_tag   (iss_tag_ff),
      .wr_valid (mac_wr_valid),
      .wr_tag   (mac_wr_tag),
      .wr_data  (mac_wr_data),
      .busy     (mac_busy)
   );

   // ---------------- response register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_READ || (state_ff == ST_DONE && rsp_free)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         rsp_entry_ff <= rd_hit_ff ? res_rd_ff : 16'd0;
         rsp_done_ff  <= 1'b0;
      end else if (state_ff == ST_DONE && rsp_free) begin
         rsp_entry_ff <= 16'd0;
         rsp_done_ff  <= 1'b1;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_entry    = rsp_entry_ff;
   assign rsp_done_res = rsp_done_ff;

   // ---------------- assertions ----------------
   a_scratch_wr_in_mul: assert property (@(posedge clock) disable iff (reset)
      mac_wr_valid |-> (state_ff == ST_MUL || state_ff == ST_DRAIN))
      else $error("scratch written outside multiply");

   a_copy_after_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY) |-> (!mac_busy && !iss_ctl_ff.valid))
      else $error("copy started with products in flight");

   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_op == OP_RUN) |=> (state_ff == ST_INIT))
      else $error("run beat did not start init");

   a_done_beat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_free) |=> (rsp_valid && rsp_done_res && rsp_entry == 16'd0))
      else $error("missing completion beat");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for modular_matrix_power_unit: base writes, power runs and reads.
// Carries its own mod-65521 matrix predictor; depends on mmp_pkg and the unit RTL.
`timescale 1ns / 1ps

module tb_top;
   import mmp_pkg::*;

   localparam int N = 64;
   localparam int CELLS = N * N;
   localparam int IDLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 20;

   typedef struct {
      op_type      op;
      logic [5:0]  row;
      logic [5:0]  col;
      logic [15:0] value;
      logic [62:0] exponent;
   } mat_beat_type;

   typedef struct {
      logic [15:0] entry;
      logic        done_res;
   } mat_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op = '0;
   logic [5:0]  req_row = '0;
   logic [5:0]  req_col = '0;
   logic [15:0] req_value = '0;
   logic [62:0] req_exponent = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_entry;
   logic        rsp_done_res;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   modular_matrix_power_unit dut (.*);

   always #5 clock = ~clock;

   mat_beat_type beat_q[$];
   mat_rsp_type  rsp_q[$];
   mat_beat_type cur_beat;
   int          tx_idle = 0, rx_idle = 0;
   int          errors = 0, idle_cycles = 0;
   int          n_write = 0, n_run = 0, n_read = 0;
   logic [6:0]  dim_reg = 7'd1;
   logic [15:0] base_mem[CELLS];
   logic [15:0] sq_mem[CELLS];
   logic [15:0] res_mem[CELLS];
   logic [15:0] prod_mem[CELLS];

   function automatic int eff_dim();
      if (dim_reg == 0) return 1;
      if (dim_reg > N) return N;
      return int'(dim_reg);
   endfunction

   // prod = x * y over the active square; picks operands by flag
   task automatic mul_mod(input bit x_is_res, input int n);
      logic [31:0] acc;
      logic [31:0] a, b;
      for (int k = 0; k < CELLS; k++) prod_mem[k] = '0;
      for (int i = 0; i < n; i++)
         for (int j = 0; j < n; j++) begin
            acc = '0;
            for (int t = 0; t < n; t++) begin
               a = x_is_res ? res_mem[i*N+t] : sq_mem[i*N+t];
               b = sq_mem[t*N+j];
               acc = 32'((64'(acc) + 64'(a * b)) % 64'(MODULUS));
            end
            prod_mem[i*N+j] = acc[15:0];
         end
   endtask

   task automatic power_run(input logic [62:0] e);
      int n;
      n = eff_dim();
      for (int k = 0; k < CELLS; k++) begin
         res_mem[k] = '0;
         sq_mem[k] = '0;
      end
      for (int i = 0; i < n; i++) begin
         res_mem[i*N+i] = 16'd1;
         for (int j = 0; j < n; j++) sq_mem[i*N+j] = base_mem[i*N+j];
      end
      while (e != 0) begin
         if (e[0]) begin
            mul_mod(1'b1, n);
            res_mem = prod_mem;
         end
         e = e >> 1;
         if (e != 0) begin
            mul_mod(1'b0, n);
            sq_mem = prod_mem;
         end
      end
   endtask

   task automatic predict_beat(input mat_beat_type b);
      mat_rsp_type r;
      case (b.op)
         OP_WRITE: begin
            base_mem[b.row*N+b.col] = (b.value >= MODULUS) ? b.value - MODULUS : b.value;
            n_write++;
         end
         OP_RUN: begin
            power_run(b.exponent);
            r.entry = '0;
            r.done_res = 1'b1;
            rsp_q.push_back(r);
            n_run++;
         end
         OP_READ: begin
            r.entry = res_mem[b.row*N+b.col];
            r.done_res = 1'b0;
            rsp_q.push_back(r);
            n_read++;
         end
         default: ;  // unused code, no response
      endcase
   endtask

   // driver: one NBA per signal per edge
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_beat(cur_beat);
         if (!req_valid || req_ready) begin
            if (beat_q.size() > 0 && $urandom_range(99) >= tx_idle) begin
               cur_beat = beat_q.pop_front();
               req_valid <= 1'b1;
               req_op <= cur_beat.op;
               req_row <= cur_beat.row;
               req_col <= cur_beat.col;
               req_value <= cur_beat.value;
               req_exponent <= cur_beat.exponent;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      mat_rsp_type exp_r;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_q.size() == 0) begin
               $error("response beat with nothing expected: entry %0d done_res %0d",
                      rsp_entry, rsp_done_res);
               errors++;
            end else begin
               exp_r = rsp_q.pop_front();
               if (rsp_entry !== exp_r.entry) begin
                  $error("entry: expected %0d actual %0d", exp_r.entry, rsp_entry);
                  errors++;
               end
               if (rsp_done_res !== exp_r.done_res) begin
                  $error("done_res: expected %0d actual %0d", exp_r.done_res, rsp_done_res);
                  errors++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= rx_idle);
      end
   end

   // watchdog on cycles with no accepted beat on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic push_beat(input op_type op, input int row, input int col,
                            input int value, input logic [62:0] e);
      mat_beat_type b;
      b.op = op;
      b.row = 6'(row);
      b.col = 6'(col);
      b.value = 16'(value);
      b.exponent = e;
      beat_q.push_back(b);
   endtask

   task automatic csr_write(input logic [6:0] v);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 3'd0;
      pwdata <= {$urandom} & ~32'h7F | 32'(v);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      dim_reg = v;
   endtask

   task automatic wait_idle();
      while (beat_q.size() > 0 || req_valid || rsp_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [62:0] rand_exp(input int bits);
      logic [62:0] e;
      e = 63'({$urandom, $urandom});
      return e >> (63 - bits);
   endfunction

   task automatic random_phase(input int count, input logic [6:0] d);
      int n, op_sel, bits;
      csr_write(d);
      n = eff_dim();
      for (int k = 0; k < count; k++) begin
         op_sel = $urandom_range(99);
         if (op_sel < 55) begin
            if ($urandom_range(9) < 8)
               push_beat(OP_WRITE, $urandom_range(n-1), $urandom_range(n-1),
                         $urandom_range(65535), '0);
            else
               push_beat(OP_WRITE, $urandom_range(63), $urandom_range(63),
                         $urandom_range(65535), rand_exp(63));
         end else if (op_sel < 92) begin
            if ($urandom_range(9) < 8) push_beat(OP_READ, $urandom_range(n-1),
                                                 $urandom_range(n-1), 0, '0);
            else push_beat(OP_READ, $urandom_range(63), $urandom_range(63),
                           $urandom_range(65535), rand_exp(63));
         end else if (op_sel < 97) begin
            bits = (n <= 4) ? $urandom_range(63, 1) : $urandom_range(10, 1);
            push_beat(OP_RUN, $urandom_range(63), $urandom_range(63),
                      $urandom_range(65535), rand_exp(bits));
         end else begin
            beat_q.push_back('{op: op_type'(2'd3), row: 6'($urandom), col: 6'($urandom),
                               value: 16'($urandom), exponent: rand_exp(63)});
         end
      end
      // sender holds off until all responses are back
      wait_idle();
   endtask

   initial begin
      for (int k = 0; k < CELLS; k++) begin
         base_mem[k] = '0;
         res_mem[k] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: dim 1 after reset, zero exponent first so reads are defined
      push_beat(OP_RUN, 0, 0, 0, '0);
      push_beat(OP_READ, 0, 0, 0, '0);
      push_beat(OP_WRITE, 0, 0, 65535, '0);
      push_beat(OP_WRITE, 0, 0, 65521, '0);
      push_beat(OP_WRITE, 0, 0, 65520, '0);
      push_beat(OP_WRITE, 63, 63, 65520, '0);
      push_beat(OP_RUN, 0, 0, 0, {63{1'b1}});
      push_beat(OP_READ, 0, 0, 0, '0);
      push_beat(OP_READ, 63, 63, 0, '0);
      beat_q.push_back('{op: op_type'(2'd3), row: 6'd63, col: 6'd63, value: 16'hFFFF,
                         exponent: {63{1'b1}}});
      wait_idle();

      csr_write(7'd0);  // acts as one
      push_beat(OP_RUN, 0, 0, 0, 63'd5);
      push_beat(OP_READ, 0, 0, 0, '0);
      wait_idle();

      csr_write(7'd2);
      push_beat(OP_WRITE, 0, 1, 12345, '0);
      push_beat(OP_WRITE, 1, 0, 65535, '0);
      push_beat(OP_WRITE, 1, 1, 7, '0);
      push_beat(OP_RUN, 0, 0, 0, {1'b0, {62{1'b1}}});
      push_beat(OP_READ, 0, 1, 0, '0);
      push_beat(OP_READ, 1, 1, 0, '0);
      push_beat(OP_READ, 0, 0, 0, '0);
      wait_idle();

      csr_write(7'd127);  // clamps to full size
      push_beat(OP_RUN, 0, 0, 0, '0);
      push_beat(OP_READ, 63, 63, 0, '0);
      wait_idle();

      csr_write(7'd64);
      push_beat(OP_RUN, 0, 0, 0, 63'd1);
      push_beat(OP_READ, 63, 63, 0, '0);
      push_beat(OP_READ, 0, 1, 0, '0);
      wait_idle();

      tx_idle = 17; rx_idle = 59;
      random_phase(260, 7'd3);
      random_phase(260, 7'd1);
      tx_idle = 59; rx_idle = 17;
      random_phase(260, 7'd8);
      random_phase(250, 7'd2);
      tx_idle = 0; rx_idle = 0;
      random_phase(260, 7'd4);
      random_phase(260, 7'($urandom_range(6, 1)));

      $display("Covered %0d writes, %0d power runs, %0d reads over dims 0..127.",
               n_write, n_run, n_read);
      $display("Handshake gaps on both channels, then none.");
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
